// File: rtl/scba_pkg.sv
// shared constants, types and helper functions of the size-class block allocator
`timescale 1ns / 1ps
`default_nettype none
package scba_pkg;

  localparam int unsigned NUM_CLASSES = 6;
  localparam int unsigned SLOTS_C0 = 1024;
  localparam int unsigned SLOTS_C1 = 256;
  localparam int unsigned SLOTS_C2 = 64;
  localparam int unsigned SLOTS_C3 = 64;
  localparam int unsigned SLOTS_C4 = 16;
  localparam int unsigned SLOTS_C5 = 16;
  localparam int unsigned SLOTS [NUM_CLASSES] = '{
    SLOTS_C0, SLOTS_C1, SLOTS_C2, SLOTS_C3, SLOTS_C4, SLOTS_C5
  };

  localparam int unsigned OFF_W = 27;
  localparam int unsigned CLS_W = 3;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned BIT_W = 5;
  localparam logic [63:0] MAX_REQUEST = 64'd4194304;

  // the largest slot count of any class sets the slot index width
  function automatic int unsigned max_slots();
    int unsigned m;
    m = 0;
    for (int k = 0; k < NUM_CLASSES; k++) begin
      if (SLOTS[k] > m) m = SLOTS[k];
    end
    return m;
  endfunction

  localparam int unsigned SLOT_W = ($clog2(max_slots()) > BIT_W) ? $clog2(max_slots()) : BIT_W;

  function automatic int unsigned block_shift(int unsigned c);
    return 7 + 3 * c;
  endfunction

  function automatic int unsigned class_words(int unsigned c);
    return (SLOTS[c] + 31) / 32;
  endfunction

  function automatic int unsigned word_base(int unsigned c);
    int unsigned b;
    b = 0;
    for (int k = 0; k < NUM_CLASSES; k++) begin
      if (k < c) b = b + class_words(k);
    end
    return b;
  endfunction

  localparam int unsigned NUM_WORDS = word_base(NUM_CLASSES);
  localparam int unsigned ADDR_W = $clog2(NUM_WORDS);

  function automatic logic [63:0] class_base(int unsigned c);
    logic [63:0] b;
    b = '0;
    for (int k = 0; k < NUM_CLASSES; k++) begin
      if (k < c) b = b + (64'(SLOTS[k]) << block_shift(k));
    end
    return b;
  endfunction

  // bits of the last bitmap word of a class that map to real slots
  function automatic logic [WORD_W-1:0] last_mask_k(int unsigned c);
    int unsigned rem;
    rem = SLOTS[c] - 32 * (class_words(c) - 1);
    if (rem >= 32) return '1;
    return (WORD_W'(1) << rem) - WORD_W'(1);
  endfunction

  // per-class lookups selected by a class code
  function automatic logic [ADDR_W-1:0] wbase(input logic [CLS_W-1:0] c);
    logic [ADDR_W-1:0] r;
    r = '0;
    for (int k = 0; k < NUM_CLASSES; k++) begin
      if (c == CLS_W'(k)) r = ADDR_W'(word_base(k));
    end
    return r;
  endfunction

  function automatic logic [ADDR_W-1:0] wlast(input logic [CLS_W-1:0] c);
    logic [ADDR_W-1:0] r;
    r = '0;
    for (int k = 0; k < NUM_CLASSES; k++) begin
      if (c == CLS_W'(k)) r = ADDR_W'(word_base(k) + class_words(k) - 1);
    end
    return r;
  endfunction

  function automatic logic [WORD_W-1:0] lmask(input logic [CLS_W-1:0] c);
    logic [WORD_W-1:0] r;
    r = '1;
    for (int k = 0; k < NUM_CLASSES; k++) begin
      if (c == CLS_W'(k)) r = last_mask_k(k);
    end
    return r;
  endfunction

  function automatic logic [OFF_W-1:0] slot_offset(input logic [CLS_W-1:0] c,
                                                   input logic [SLOT_W-1:0] s);
    logic [63:0] r;
    r = '0;
    for (int k = 0; k < NUM_CLASSES; k++) begin
      if (c == CLS_W'(k)) r = class_base(k) + (64'(s) << block_shift(k));
    end
    return r[OFF_W-1:0];
  endfunction

  typedef enum logic [1:0] {
    CMD_FAIL,
    CMD_ALLOC,
    CMD_FREE
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t            op;
    logic [CLS_W-1:0]   cls;
    logic [SLOT_W-1:0]  slot;
  } cmd_t;

endpackage
`default_nettype wire

// File: rtl/scba_if.sv
// request and response channel interfaces
`timescale 1ns / 1ps
`default_nettype none
interface scba_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [31:0] elem_bytes;
  logic [31:0] elem_num;
  logic [26:0] free_offset;
  modport source (output valid, kind, elem_bytes, elem_num, free_offset, input ready);
  modport sink (input valid, kind, elem_bytes, elem_num, free_offset, output ready);
endinterface

interface scba_out_if;
  logic        valid;
  logic        ready;
  logic        ok;
  logic [26:0] block_offset;
  logic [2:0]  size_class;
  modport source (output valid, ok, block_offset, size_class, input ready);
  modport sink (input valid, ok, block_offset, size_class, output ready);
endinterface
`default_nettype wire

// File: rtl/scba_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module scba_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem[rd_addr];
  end
endmodule
`default_nettype wire

// File: rtl/scba_front.sv
// front end: accepts requests, forms the size product and classifies them
`timescale 1ns / 1ps
`default_nettype none
module scba_front
  import scba_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  scba_in_if.sink   req,
  output logic      push_valid,
  input  wire logic push_ready,
  output cmd_t      push_cmd
);
  logic             st_vld;
  logic             st_kind;
  logic [63:0]      st_prod;
  logic [OFF_W-1:0] st_off;

  logic [CLS_W-1:0] cls_a;
  logic [CLS_W-1:0] cls_f;
  logic [63:0]      off64;
  logic [63:0]      slot64;
  logic             slot_ok;

  assign req.ready  = !st_vld || push_ready;
  assign push_valid = st_vld;

  // stage register, product registered right after the multiplier
  always_ff @(posedge clk) begin
    if (rst) begin
      st_vld <= 1'b0;
    end else if (req.valid && req.ready) begin
      st_vld <= 1'b1;
    end else if (push_ready) begin
      st_vld <= 1'b0;
    end
    if (req.valid && req.ready) begin
      st_kind <= req.kind;
      st_prod <= 64'(req.elem_bytes) * 64'(req.elem_num);
      st_off  <= req.free_offset;
    end
  end

  // classify the registered item
  always_comb begin
    cls_a = '0;
    for (int k = 0; k < NUM_CLASSES - 1; k++) begin
      if (st_prod >= (64'd1 << block_shift(k))) cls_a = CLS_W'(k + 1);
    end
    off64 = 64'(st_off);
    cls_f = '0;
    for (int k = 1; k < NUM_CLASSES; k++) begin
      if (off64 >= class_base(k)) cls_f = CLS_W'(k);
    end
    slot64  = '0;
    slot_ok = 1'b0;
    for (int k = 0; k < NUM_CLASSES; k++) begin
      if (cls_f == CLS_W'(k)) begin
        slot64  = (off64 - class_base(k)) >> block_shift(k);
        slot_ok = slot64 < 64'(SLOTS[k]);
      end
    end
    push_cmd.slot = slot64[SLOT_W-1:0];
    if (st_kind) begin
      push_cmd.op  = slot_ok ? CMD_FREE : CMD_FAIL;
      push_cmd.cls = cls_f;
    end else if (st_prod == 64'd0 || st_prod >= MAX_REQUEST) begin
      push_cmd.op  = CMD_FAIL;
      push_cmd.cls = '0;
    end else begin
      push_cmd.op  = CMD_ALLOC;
      push_cmd.cls = cls_a;
    end
  end
endmodule
`default_nettype wire

// File: rtl/scba_queue.sv
// two-entry command queue between front and back
`timescale 1ns / 1ps
`default_nettype none
module scba_queue
  import scba_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push_valid,
  output logic      push_ready,
  input  wire cmd_t push_cmd,
  output logic      pop_valid,
  input  wire logic pop_ready,
  output cmd_t      pop_cmd
);
  cmd_t       entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] cnt;
  logic       do_push;
  logic       do_pop;

  assign push_ready = cnt != 2'd2;
  assign pop_valid  = cnt != 2'd0;
  assign pop_cmd    = entry[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= !wr_ptr;
      if (do_pop) rd_ptr <= !rd_ptr;
      cnt <= cnt + 2'(do_push) - 2'(do_pop);
    end
    if (do_push) entry[wr_ptr] <= push_cmd;
  end
endmodule
`default_nettype wire

// File: rtl/scba_back.sv
// back end: held and saved slots, bitmap scan and update, result register
`timescale 1ns / 1ps
`default_nettype none
module scba_back
  import scba_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic q_valid,
  output logic      q_pop,
  input  wire cmd_t q_cmd,
  scba_out_if.source rsp
);
  typedef enum logic [1:0] {S_IDLE, S_RMW, S_SCAN, S_DONE} state_t;

  state_t            state;
  logic              held_valid [NUM_CLASSES];
  logic [SLOT_W-1:0] held_slot [NUM_CLASSES];
  logic [SLOT_W-1:0] saved_slot [NUM_CLASSES];
  logic              word_valid [NUM_WORDS];
  logic [CLS_W-1:0]  cur_cls;
  logic [SLOT_W-1:0] cur_slot;
  logic              rmw_set;
  logic [ADDR_W-1:0] rmw_addr;
  logic [ADDR_W-1:0] chk_addr;
  logic              rd_wv;
  logic              res_ok;
  logic              res_alloc;
  logic [SLOT_W-1:0] res_slot;
  logic              out_vld;
  logic              out_ok;
  logic [OFF_W-1:0]  out_off;
  logic [CLS_W-1:0]  out_cls;

  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [WORD_W-1:0] rd_data;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [WORD_W-1:0] wr_data;
  logic [WORD_W-1:0] eff;
  logic [WORD_W-1:0] scan_word;
  logic              found;
  logic [BIT_W-1:0]  found_bit;
  logic              chk_last;
  logic [SLOT_W-1:0] scan_slot;
  logic [WORD_W-1:0] rmw_bit;
  logic [SLOT_W-1:0] c_saved;
  logic              c_held;
  logic              out_free;

  scba_ram #(.WIDTH(WORD_W), .DEPTH(NUM_WORDS)) u_map (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign rsp.valid        = out_vld;
  assign rsp.ok           = out_ok;
  assign rsp.block_offset = out_off;
  assign rsp.size_class   = out_cls;
  assign out_free         = !out_vld || rsp.ready;
  assign q_pop            = state == S_IDLE && q_valid;
  assign c_held           = held_valid[q_cmd.cls];
  assign c_saved          = saved_slot[q_cmd.cls];

  // bitmap word as read, never-written words count as all free
  assign eff      = rd_data & {WORD_W{rd_wv}};
  assign chk_last = chk_addr == wlast(cur_cls);
  assign scan_word = chk_last ? (eff | ~lmask(cur_cls)) : eff;
  assign rmw_bit  = WORD_W'(1) << cur_slot[BIT_W-1:0];

  // first clear bit of the scanned word
  always_comb begin
    found     = 1'b0;
    found_bit = '0;
    for (int b = WORD_W - 1; b >= 0; b--) begin
      if (!scan_word[b]) begin
        found     = 1'b1;
        found_bit = BIT_W'(b);
      end
    end
    scan_slot = SLOT_W'({(chk_addr - wbase(cur_cls)), found_bit});
  end

  // bitmap read address
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    if (q_pop && q_cmd.op == CMD_ALLOC && !c_held) begin
      rd_en = 1'b1;
      if (c_saved != '0) begin
        rd_addr = wbase(q_cmd.cls) + ADDR_W'(c_saved >> BIT_W);
      end else begin
        rd_addr = wbase(q_cmd.cls);
      end
    end else if (q_pop && q_cmd.op == CMD_FREE && c_held) begin
      rd_en   = 1'b1;
      rd_addr = wbase(q_cmd.cls) + ADDR_W'(q_cmd.slot >> BIT_W);
    end else if (state == S_SCAN && !found && !chk_last) begin
      rd_en   = 1'b1;
      rd_addr = chk_addr + ADDR_W'(1);
    end
  end

  // bitmap write
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = rmw_addr;
    wr_data = rmw_set ? (eff | rmw_bit) : (eff & ~rmw_bit);
    if (state == S_RMW) begin
      wr_en = 1'b1;
    end else if (state == S_SCAN && found) begin
      wr_en   = 1'b1;
      wr_addr = chk_addr;
      wr_data = eff | (WORD_W'(1) << found_bit);
    end
  end

  // sequencer, class state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      out_vld <= 1'b0;
      for (int k = 0; k < NUM_CLASSES; k++) begin
        held_valid[k] <= 1'b0;
        saved_slot[k] <= '0;
      end
      for (int w = 0; w < NUM_WORDS; w++) word_valid[w] <= 1'b0;
    end else begin
      if (state == S_DONE && out_free) begin
        out_vld <= 1'b1;
      end else if (rsp.ready) begin
        out_vld <= 1'b0;
      end
      if (wr_en) word_valid[wr_addr] <= 1'b1;
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            cur_cls   <= q_cmd.cls;
            cur_slot  <= (q_cmd.op == CMD_ALLOC && !c_held) ? c_saved : q_cmd.slot;
            rmw_addr  <= rd_addr;
            chk_addr  <= rd_addr;
            res_ok    <= q_cmd.op != CMD_FAIL;
            res_alloc <= q_cmd.op == CMD_ALLOC;
            case (q_cmd.op)
              CMD_ALLOC: begin
                if (c_held) begin
                  held_valid[q_cmd.cls] <= 1'b0;
                  res_slot <= held_slot[q_cmd.cls];
                  state    <= S_DONE;
                end else if (c_saved != '0) begin
                  saved_slot[q_cmd.cls] <= '0;
                  res_slot <= c_saved;
                  rmw_set  <= 1'b1;
                  state    <= S_RMW;
                end else begin
                  state <= S_SCAN;
                end
              end
              CMD_FREE: begin
                if (!c_held) begin
                  held_valid[q_cmd.cls] <= 1'b1;
                  held_slot[q_cmd.cls]  <= q_cmd.slot;
                  state <= S_DONE;
                end else begin
                  saved_slot[q_cmd.cls] <= q_cmd.slot;
                  rmw_set <= 1'b0;
                  state   <= S_RMW;
                end
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
        end
        S_RMW: begin
          state <= S_DONE;
        end
        S_SCAN: begin
          if (found) begin
            res_slot <= scan_slot;
            state    <= S_DONE;
          end else if (chk_last) begin
            res_ok <= 1'b0;
            state  <= S_DONE;
          end else begin
            chk_addr <= rd_addr;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_ok  <= res_ok;
            out_cls <= cur_cls;
            out_off <= (res_ok && res_alloc) ? slot_offset(cur_cls, res_slot) : '0;
            state   <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
    if (rd_en) rd_wv <= word_valid[rd_addr];
  end

  // scan stays within the words of its class
  a_scan_low: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |-> chk_addr >= wbase(cur_cls)) else $error("scan below class");
  a_scan_high: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |-> chk_addr <= wlast(cur_cls)) else $error("scan past class");
  // a read-modify-write moves to the done state in the next cycle
  a_rmw_done: assert property (@(posedge clk) disable iff (rst)
    state == S_RMW |=> state == S_DONE) else $error("rmw did not finish");
  // a result waiting on a stalled receiver is not overwritten
  a_hold: assert property (@(posedge clk) disable iff (rst)
    state == S_DONE && !out_free |=> state == S_DONE) else $error("result lost");
endmodule
`default_nettype wire

// File: rtl/size_class_block_allocator_unit.sv
// top level of the size-class block allocator
// Usage: requests arrive on req (valid/ready). kind 0 allocates
// elem_bytes * elem_num bytes, kind 1 frees the block at
// free_offset. Each request gives one response on rsp (valid/ready) with
// ok, block_offset and size_class, in request order.
// Failures, held-block returns and frees into an empty hold slot go from the
// idle state straight to the done state; a bitmap update passes through a
// read-modify-write state first. A first-free search reads one 32-bit bitmap
// word per cycle from the bitmap ram, up to 32 words for the 128 B class.
// The back end takes one item at a time and pops the next only when idle.
// The front keeps accepting while the back end works, up to the two-entry
// queue plus the front stage.
// Reset: all classes empty, nothing held or saved. Bitmap words carry a
// written flag that reset clears, so no clearing pass is needed and the
// block takes items in the first cycle after reset.
// A stalled rsp holds its item; the back end waits with its next result and
// the queue fills, after which req.ready drops.
`timescale 1ns / 1ps
`default_nettype none
module size_class_block_allocator_unit
  import scba_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  scba_in_if.sink    req,
  scba_out_if.source rsp
);
  logic push_valid;
  logic push_ready;
  cmd_t push_cmd;
  logic pop_valid;
  logic pop_ready;
  cmd_t pop_cmd;

  scba_front u_front (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  scba_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  scba_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (pop_valid),
    .q_pop   (pop_ready),
    .q_cmd   (pop_cmd),
    .rsp     (rsp)
  );
endmodule
`default_nettype wire
